// ===== design/assert_macros.svh =====
// Assertion macros shared by the equalizer design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, prop, msg)
`define ASSERT_ANY(lbl, prop, msg)
`endif
`endif

// ===== design/tbe_pkg.sv =====
// Constants, types and rounding helpers of the three-band equaliser.
package tbe_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int COEF_BITS    = 26;
  localparam int GAIN_BITS    = 24;
  localparam int GAIN_FRAC    = 22;
  localparam int COEF_FRAC    = COEF_BITS - 4;
  localparam int NUM_SEC      = 3;
  localparam int TAPS         = 5;
  localparam int NUM_COEF     = NUM_SEC * TAPS;
  localparam int HIST_PER_SEC = 4;
  localparam int NUM_HIST     = NUM_SEC * HIST_PER_SEC;
  localparam int IDX_BITS     = 4;
  localparam int SEC_BITS     = 2;
  localparam int STEP_BITS    = 3;
  localparam int HIST_BITS    = $clog2(NUM_HIST);
  localparam int CFG_IDX_BITS = 2;
  localparam int MUL_A_BITS   = (COEF_BITS > GAIN_BITS + 1) ? COEF_BITS : GAIN_BITS + 1;
  localparam int PROD_BITS    = MUL_A_BITS + SAMPLE_BITS;
  localparam int ACC_BITS     = (PROD_BITS + 3 > 64) ? 64 : PROD_BITS + 3;

  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_COEF   = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] REG_BASS   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MID    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TREBLE = 2'd2;

  localparam logic [STEP_BITS-1:0] SLOT_B0 = 3'd0;
  localparam logic [STEP_BITS-1:0] SLOT_B1 = 3'd1;
  localparam logic [STEP_BITS-1:0] SLOT_B2 = 3'd2;
  localparam logic [STEP_BITS-1:0] SLOT_A1 = 3'd3;
  localparam logic [STEP_BITS-1:0] SLOT_A2 = 3'd4;

  localparam logic [SEC_BITS-1:0] SEC_LOW  = 2'd0;
  localparam logic [SEC_BITS-1:0] SEC_MID  = 2'd1;
  localparam logic [SEC_BITS-1:0] SEC_HIGH = 2'd2;

  typedef struct packed {
    logic                 load_x;
    logic                 coef_we;
    logic                 mul_coef;
    logic                 mul_gain;
    logic                 acc_clr;
    logic                 acc_add;
    logic                 round_y;
    logic                 round_g;
    logic                 out_load;
    logic [SEC_BITS-1:0]  sec;
    logic [STEP_BITS-1:0] step;
  } tbe_cmd_t;

  typedef struct packed {
    logic out_free;
  } tbe_stat_t;

  typedef struct packed {
    logic                          clip;
    logic signed [SAMPLE_BITS-1:0] val;
  } tbe_sat_t;

  // Round half up, shift right arithmetically by frac, saturate to a sample.
  function automatic tbe_sat_t round_sat(input logic signed [ACC_BITS-1:0] v, input int frac);
    logic signed [ACC_BITS:0] half;
    logic signed [ACC_BITS:0] t;
    logic signed [ACC_BITS:0] s;
    logic signed [ACC_BITS:0] hi;
    logic signed [ACC_BITS:0] lo;
    tbe_sat_t                 r;
    half = '0;
    half[frac-1] = 1'b1;
    t = {v[ACC_BITS-1], v};
    t = t + half;
    s = t >>> frac;
    hi = {{(ACC_BITS - SAMPLE_BITS + 2){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    lo = {{(ACC_BITS - SAMPLE_BITS + 2){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};
    if (s > hi) begin
      r.clip = 1'b1;
      r.val  = hi[SAMPLE_BITS-1:0];
    end else if (s < lo) begin
      r.clip = 1'b1;
      r.val  = lo[SAMPLE_BITS-1:0];
    end else begin
      r.clip = 1'b0;
      r.val  = s[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/tbe_ctrl.sv =====
// Sequencer that steps the shared multiply-accumulate through the three sections.
module tbe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                cmd_i,
  output logic                in_ready_o,
  input  tbe_pkg::tbe_stat_t  stat_i,
  output tbe_pkg::tbe_cmd_t   cmd_o
);
  import tbe_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MAC   = 3'd1;
  localparam logic [2:0] S_FLUSH = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_GMUL  = 3'd4;
  localparam logic [2:0] S_GRND  = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [SEC_BITS-1:0]  sec_q, sec_d;
  logic [STEP_BITS-1:0] step_q, step_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    sec_d   = sec_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.sec  = sec_q;
    cmd_o.step = step_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (cmd_i == CMD_COEF) begin
            cmd_o.coef_we = 1'b1;
          end else begin
            cmd_o.load_x = 1'b1;
            sec_d   = SEC_LOW;
            step_d  = SLOT_B0;
            state_d = S_MAC;
          end
        end
      end
      S_MAC: begin
        cmd_o.mul_coef = 1'b1;
        if (step_q == SLOT_B0) begin
          cmd_o.acc_clr = 1'b1;
        end else begin
          cmd_o.acc_add = 1'b1;
        end
        if (step_q == SLOT_A2) begin
          state_d = S_FLUSH;
        end else begin
          step_d = step_q + STEP_BITS'(1);
        end
      end
      S_FLUSH: begin
        cmd_o.acc_add = 1'b1;
        state_d = S_ROUND;
      end
      S_ROUND: begin
        cmd_o.round_y = 1'b1;
        state_d = S_GMUL;
      end
      S_GMUL: begin
        cmd_o.mul_gain = 1'b1;
        state_d = S_GRND;
      end
      S_GRND: begin
        if (sec_q == SEC_HIGH) begin
          if (stat_i.out_free) begin
            cmd_o.round_g  = 1'b1;
            cmd_o.out_load = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          cmd_o.round_g = 1'b1;
          sec_d   = sec_q + SEC_BITS'(1);
          step_d  = SLOT_B0;
          state_d = S_MAC;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sec_q   <= SEC_LOW;
      step_q  <= SLOT_B0;
    end else begin
      state_q <= state_d;
      sec_q   <= sec_d;
      step_q  <= step_d;
    end
  end

endmodule

// ===== design/tbe_datapath.sv =====
// Coefficient table, filter history, gains, shared multiplier, accumulator and result register.
module tbe_datapath (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  tbe_pkg::tbe_cmd_t                       cmd_i,
  output tbe_pkg::tbe_stat_t                      stat_o,
  input  logic [tbe_pkg::IDX_BITS-1:0]            coef_index_i,
  input  logic signed [tbe_pkg::COEF_BITS-1:0]    coef_value_i,
  input  logic signed [tbe_pkg::SAMPLE_BITS-1:0]  sample_in_i,
  input  logic                                    cfg_we_i,
  input  logic [tbe_pkg::CFG_IDX_BITS-1:0]        cfg_index_i,
  input  logic [tbe_pkg::GAIN_BITS-1:0]           cfg_data_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [tbe_pkg::SAMPLE_BITS-1:0]  sample_out_o,
  output logic                                    clipped_o
);
  import tbe_pkg::*;

  logic signed [COEF_BITS-1:0]   coef_q [NUM_COEF];
  logic signed [SAMPLE_BITS-1:0] hist_q [NUM_HIST];
  logic [GAIN_BITS-1:0]          bass_q, mid_q, treble_q;
  logic signed [SAMPLE_BITS-1:0] x_q, y_q;
  logic                          clip_q;
  logic signed [PROD_BITS-1:0]   p_q, p_d;
  logic                          p_neg_q;
  logic signed [ACC_BITS-1:0]    acc_q, acc_d, p_ext;
  logic [IDX_BITS-1:0]           coef_addr;
  logic [HIST_BITS-1:0]          hist_addr;
  logic [GAIN_BITS-1:0]          gain_sel;
  logic signed [MUL_A_BITS-1:0]  mul_a;
  logic signed [SAMPLE_BITS-1:0] mul_b;
  tbe_sat_t                      y_sat, g_sat;
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_sample_q;
  logic                          out_clip_q;

  assign coef_addr = IDX_BITS'(cmd_i.sec) * IDX_BITS'(TAPS) + IDX_BITS'(cmd_i.step);
  assign hist_addr = HIST_BITS'(cmd_i.sec) * HIST_BITS'(HIST_PER_SEC)
                   + HIST_BITS'(cmd_i.step) - HIST_BITS'(1);

  always_comb begin
    unique case (cmd_i.sec)
      SEC_LOW: gain_sel = bass_q;
      SEC_MID: gain_sel = mid_q;
      default: gain_sel = treble_q;
    endcase
  end

  always_comb begin
    if (cmd_i.mul_gain) begin
      mul_a = signed'({{(MUL_A_BITS - GAIN_BITS){1'b0}}, gain_sel});
      mul_b = y_q;
    end else begin
      mul_a = MUL_A_BITS'(coef_q[coef_addr]);
      mul_b = (cmd_i.step == SLOT_B0) ? x_q : hist_q[hist_addr];
    end
  end

  assign p_d   = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
  assign p_ext = ACC_BITS'(p_q);

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.acc_clr) begin
      acc_d = '0;
    end else if (cmd_i.acc_add) begin
      acc_d = p_neg_q ? (acc_q - p_ext) : (acc_q + p_ext);
    end
  end

  assign y_sat = round_sat(acc_q, COEF_FRAC);
  assign g_sat = round_sat(p_ext, GAIN_FRAC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_q[i] <= (i % TAPS == 0) ? (COEF_BITS'(1) <<< COEF_FRAC) : '0;
      end
    end else if (cmd_i.coef_we && (coef_index_i < IDX_BITS'(NUM_COEF))) begin
      coef_q[coef_index_i] <= coef_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_HIST; i++) begin
        hist_q[i] <= '0;
      end
    end else if (cmd_i.round_y) begin
      for (int s = 0; s < NUM_SEC; s++) begin
        if (cmd_i.sec == SEC_BITS'(s)) begin
          hist_q[s*HIST_PER_SEC]     <= x_q;
          hist_q[s*HIST_PER_SEC + 1] <= hist_q[s*HIST_PER_SEC];
          hist_q[s*HIST_PER_SEC + 2] <= y_sat.val;
          hist_q[s*HIST_PER_SEC + 3] <= hist_q[s*HIST_PER_SEC + 2];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bass_q   <= GAIN_BITS'(1) << GAIN_FRAC;
      mid_q    <= GAIN_BITS'(1) << GAIN_FRAC;
      treble_q <= GAIN_BITS'(1) << GAIN_FRAC;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_BASS) begin
        bass_q <= cfg_data_i;
      end
      if (cfg_index_i == REG_MID) begin
        mid_q <= cfg_data_i;
      end
      if (cfg_index_i == REG_TREBLE) begin
        treble_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_coef || cmd_i.mul_gain) begin
      p_q     <= p_d;
      p_neg_q <= cmd_i.mul_coef && (cmd_i.step >= SLOT_A1);
    end
    acc_q <= acc_d;
    if (cmd_i.round_y) begin
      y_q <= y_sat.val;
    end
    if (cmd_i.load_x) begin
      x_q <= sample_in_i;
    end else if (cmd_i.round_g) begin
      x_q <= g_sat.val;
    end
    if (cmd_i.load_x) begin
      clip_q <= 1'b0;
    end else if (cmd_i.round_y) begin
      clip_q <= clip_q | y_sat.clip;
    end else if (cmd_i.round_g) begin
      clip_q <= clip_q | g_sat.clip;
    end
    if (cmd_i.out_load) begin
      out_sample_q <= g_sat.val;
      out_clip_q   <= clip_q | g_sat.clip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_sample_q;
  assign clipped_o    = out_clip_q;

endmodule

// ===== design/three_band_biquad_equalizer.sv =====
// Top level of the three-band biquad equaliser: sequencer, datapath and checks.
//
// A filter request (cmd 0) keeps the block busy while one shared 26 x 24 bit multiplier
// with a product register runs each of the three sections as five coefficient products,
// one accumulate of the last product, rounding, gain product and gain rounding, and
// the last section waits at gain rounding while the previous result has not been taken;
// only then does the block take a new request.
// A coefficient write request (cmd 1) leaves the block ready and gives no result.
// The result register lets a finished sample wait while a new request enters.
// The user must write the gain registers through the configuration port only while idle; the block does not enforce it.
module three_band_biquad_equalizer (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic                                    cmd_i,
  input  logic [tbe_pkg::IDX_BITS-1:0]            coef_index_i,
  input  logic signed [tbe_pkg::COEF_BITS-1:0]    coef_value_i,
  input  logic signed [tbe_pkg::SAMPLE_BITS-1:0]  sample_in_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [tbe_pkg::SAMPLE_BITS-1:0]  sample_out_o,
  output logic                                    clipped_o,
  input  logic                                    cfg_we_i,
  input  logic [tbe_pkg::CFG_IDX_BITS-1:0]        cfg_index_i,
  input  logic [tbe_pkg::GAIN_BITS-1:0]           cfg_data_i
);
  import tbe_pkg::*;
`include "assert_macros.svh"

  tbe_cmd_t  cmd;
  tbe_stat_t stat;
  logic      filt_req;
  logic      coef_req;

  assign filt_req = in_valid_i && in_ready_o && (cmd_i == CMD_FILTER);
  assign coef_req = in_valid_i && in_ready_o && (cmd_i == CMD_COEF);

  tbe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tbe_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .coef_index_i (coef_index_i),
    .coef_value_i (coef_value_i),
    .sample_in_i  (sample_in_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o),
    .clipped_o    (clipped_o)
  );

  `ASSERT_RST(a_busy_after_filter, filt_req |=> !in_ready_o, "ready after a filter request")
  `ASSERT_RST(a_coef_silent, coef_req |=> !$rose(out_valid_o), "coefficient write gave a result")
  `ASSERT_RST(a_result_at_idle, $rose(out_valid_o) |-> in_ready_o, "result while still busy")

endmodule
